@@ rtl/cnms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cnms_pkg;

  localparam int DefMaxWidth = 1024;
  localparam int DefMagBits  = 16;

  localparam int AngBits    = 15;
  localparam int FwBits     = 11;
  localparam int FhBits     = 16;
  localparam int CfgBits    = 16;
  localparam int CfgIdxBits = 1;

  localparam int FwReset = 640;
  localparam int FhReset = 480;

  localparam int PiQ12  = 12868;
  localparam int TSect0 = 1608;
  localparam int TSect1 = 4825;
  localparam int TSect2 = 8042;
  localparam int TSect3 = 11259;

  localparam int FifoDepth = 8;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cnms_reg_e;

  typedef enum logic [1:0] {
    SECT_VERT    = 2'd0,
    SECT_DIAG_DN = 2'd1,
    SECT_HORZ    = 2'd2,
    SECT_DIAG_UP = 2'd3
  } cnms_sector_e;

  typedef struct packed {
    logic         vld;
    logic         frame_end;
    logic [3:0]   ok_lo;
    logic [3:0]   ok_hi;
    cnms_sector_e sector;
    logic         supp;
  } cnms_tok_t;

endpackage

`default_nettype wire

@@ rtl/canny_nonmax_suppression_core.sv @@
// A released result passes token register, center bank, earlier and later cell; the
//   releasing beat is one row plus one pixel after its pixel, or is a flush beat.
// Throughput: one input beat per cycle unless credit runs out; set by one write and
//   one read per cycle on each history bank (center bank, earlier and later cell).
// Reset: control state clears at once; history banks are not cleared and
//   need no clearing pass, so the first beat is taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module canny_nonmax_suppression_core #(
  parameter int  MAX_WIDTH = cnms_pkg::DefMaxWidth,
  parameter int  MAG_BITS  = cnms_pkg::DefMagBits,
  localparam int IN_W      = ((MAG_BITS + cnms_pkg::AngBits + 7) / 8) * 8,
  localparam int OUT_W     = ((MAG_BITS + 7) / 8) * 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // grad_magnitude, grad_angle
  input  wire [IN_W-1:0]                   s_axis_tdata,
  // command
  input  wire                              s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // thinned_magnitude
  output logic [OUT_W-1:0]                 m_axis_tdata,
  output logic                             m_axis_tlast,
  input  wire                              cfg_we_i,
  input  wire [cnms_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  wire [cnms_pkg::CfgBits-1:0]      cfg_wdata_i
);

  localparam int AW     = $clog2(2 * MAX_WIDTH + 8);
  localparam int W_BITS = $clog2(MAX_WIDTH + 1);
  localparam int PW     = $clog2(MAX_WIDTH + 3);
  localparam int FPW    = $clog2(cnms_pkg::FifoDepth);
  localparam int FCW    = $clog2(cnms_pkg::FifoDepth + 1);

  logic [cnms_pkg::FwBits-1:0] width_q;
  logic [cnms_pkg::FhBits-1:0] height_q;
  logic [cnms_pkg::FwBits-1:0] w_lo;
  logic [W_BITS-1:0]           w_eff;
  logic [cnms_pkg::FhBits-1:0] h_eff;

  logic [PW-1:0]     pend_q, pend_d, p_emit, w_p, w_p1;
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [W_BITS-1:0] col_q;
  logic [cnms_pkg::FhBits-1:0] row_q;

  logic s_beat, pix, flush, emit, m_beat;
  logic up, dn, lf, rt;

  logic [MAG_BITS-1:0]        in_mag;
  logic signed [cnms_pkg::AngBits-1:0] in_ang;
  logic signed [cnms_pkg::AngBits:0]   ang_fold;
  cnms_pkg::cnms_sector_e     in_sector;

  cnms_pkg::cnms_tok_t tok0_q, tok0_d, tok1, tok2, tok3;
  logic [AW-1:0]       addr0_q, addr1, addr2;
  logic [MAG_BITS-1:0] cmag1, cmag2, cmag3;

  logic [FCW-1:0]      cred_q, fcnt_q;
  logic [FPW-1:0]      fwp_q, frp_q;
  logic [MAG_BITS-1:0] fmag_q [cnms_pkg::FifoDepth];
  logic                fend_q [cnms_pkg::FifoDepth];
  logic                fifo_wr;

  // effective frame geometry
  always_comb begin
    w_lo  = (width_q < cnms_pkg::FwBits'(2)) ? cnms_pkg::FwBits'(2) : width_q;
    w_eff = (32'(w_lo) > 32'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH) : W_BITS'(w_lo);
    h_eff = (height_q < cnms_pkg::FhBits'(2)) ? cnms_pkg::FhBits'(2) : height_q;
    w_p   = PW'(w_eff);
    w_p1  = w_p + PW'(1);
  end

  assign s_axis_tready = (cred_q < FCW'(cnms_pkg::FifoDepth));
  assign s_beat        = s_axis_tvalid & s_axis_tready;
  assign pix           = s_beat & ~s_axis_tuser;
  assign flush         = s_beat & s_axis_tuser;
  assign m_beat        = m_axis_tvalid & m_axis_tready;

  assign in_mag = s_axis_tdata[MAG_BITS-1:0];
  assign in_ang = s_axis_tdata[MAG_BITS+cnms_pkg::AngBits-1:MAG_BITS];

  always_comb begin
    ang_fold = in_ang[cnms_pkg::AngBits-1]
             ? ((cnms_pkg::AngBits+1)'(in_ang) + (cnms_pkg::AngBits+1)'(cnms_pkg::PiQ12))
             : (cnms_pkg::AngBits+1)'(in_ang);
    priority if (int'(ang_fold) <= cnms_pkg::TSect0 || int'(ang_fold) > cnms_pkg::TSect3) begin
      in_sector = cnms_pkg::SECT_VERT;
    end else if (int'(ang_fold) <= cnms_pkg::TSect1) begin
      in_sector = cnms_pkg::SECT_DIAG_DN;
    end else if (int'(ang_fold) <= cnms_pkg::TSect2) begin
      in_sector = cnms_pkg::SECT_HORZ;
    end else begin
      in_sector = cnms_pkg::SECT_DIAG_UP;
    end
  end

  // release of the oldest owed pixel
  always_comb begin
    emit   = pix ? (pend_q == w_p1) : (flush & (pend_q != '0));
    p_emit = pix ? (pend_q + PW'(1)) : pend_q;
    if (pix & ~emit) begin
      pend_d = pend_q + PW'(1);
    end else if (flush & emit) begin
      pend_d = pend_q - PW'(1);
    end else begin
      pend_d = pend_q;
    end
  end

  always_comb begin
    up = (row_q != '0);
    dn = (row_q != h_eff - cnms_pkg::FhBits'(1));
    lf = (col_q != '0);
    rt = (col_q != w_eff - W_BITS'(1));
    tok0_d           = '0;
    tok0_d.vld       = emit;
    tok0_d.frame_end = ~dn & ~rt;
    tok0_d.ok_lo[cnms_pkg::SECT_VERT]    = up;
    tok0_d.ok_lo[cnms_pkg::SECT_DIAG_DN] = up & lf;
    tok0_d.ok_lo[cnms_pkg::SECT_HORZ]    = lf;
    tok0_d.ok_lo[cnms_pkg::SECT_DIAG_UP] = up & rt;
    tok0_d.ok_hi[cnms_pkg::SECT_VERT]    = dn & (p_emit > w_p);
    tok0_d.ok_hi[cnms_pkg::SECT_DIAG_DN] = dn & rt & (p_emit > w_p1);
    tok0_d.ok_hi[cnms_pkg::SECT_HORZ]    = rt & (p_emit > PW'(1));
    tok0_d.ok_hi[cnms_pkg::SECT_DIAG_UP] = dn & lf & (p_emit > w_p - PW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cnms_pkg::FwBits'(cnms_pkg::FwReset);
      height_q <= cnms_pkg::FhBits'(cnms_pkg::FhReset);
      pend_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      tok0_q   <= '0;
    end else begin
      tok0_q <= tok0_d;
      if (pix) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (cfg_we_i) begin
        unique case (cnms_pkg::cnms_reg_e'(cfg_idx_i))
          cnms_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[cnms_pkg::FwBits-1:0];
          cnms_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
          default:                    width_q  <= width_q;
        endcase
        pend_q   <= '0;
        rd_ptr_q <= wr_ptr_q;
        col_q    <= '0;
        row_q    <= '0;
      end else begin
        pend_q <= pend_d;
        if (emit) begin
          rd_ptr_q <= rd_ptr_q + AW'(1);
          if (~rt) begin
            col_q <= '0;
            row_q <= dn ? (row_q + cnms_pkg::FhBits'(1)) : '0;
          end else begin
            col_q <= col_q + W_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr0_q <= rd_ptr_q;
  end

  cnms_center #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAG_BITS  (MAG_BITS)
  ) u_center (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (pix),
    .wr_addr_i   (wr_ptr_q),
    .wr_mag_i    (in_mag),
    .wr_sector_i (in_sector),
    .tok_i       (tok0_q),
    .addr_i      (addr0_q),
    .tok_o       (tok1),
    .addr_o      (addr1),
    .cmag_o      (cmag1)
  );

  cnms_cell #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAG_BITS   (MAG_BITS),
    .LATER_SIDE (1'b0)
  ) u_cell_lo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (pix),
    .wr_addr_i (wr_ptr_q),
    .wr_mag_i  (in_mag),
    .width_i   (w_eff),
    .tok_i     (tok1),
    .addr_i    (addr1),
    .cmag_i    (cmag1),
    .tok_o     (tok2),
    .addr_o    (addr2),
    .cmag_o    (cmag2)
  );

  cnms_cell #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAG_BITS   (MAG_BITS),
    .LATER_SIDE (1'b1)
  ) u_cell_hi (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (pix),
    .wr_addr_i (wr_ptr_q),
    .wr_mag_i  (in_mag),
    .width_i   (w_eff),
    .tok_i     (tok2),
    .addr_i    (addr2),
    .cmag_i    (cmag2),
    .tok_o     (tok3),
    .addr_o    (),
    .cmag_o    (cmag3)
  );

  assign fifo_wr = tok3.vld;

  always_ff @(posedge clk_i) begin
    if (fifo_wr) begin
      fmag_q[fwp_q] <= tok3.supp ? '0 : cmag3;
      fend_q[fwp_q] <= tok3.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
      fcnt_q <= '0;
      fwp_q  <= '0;
      frp_q  <= '0;
    end else begin
      cred_q <= cred_q + FCW'(emit) - FCW'(m_beat);
      fcnt_q <= fcnt_q + FCW'(fifo_wr) - FCW'(m_beat);
      if (fifo_wr) begin
        fwp_q <= fwp_q + FPW'(1);
      end
      if (m_beat) begin
        frp_q <= frp_q + FPW'(1);
      end
    end
  end

  assign m_axis_tvalid = (fcnt_q != '0);
  assign m_axis_tdata  = OUT_W'(fmag_q[frp_q]);
  assign m_axis_tlast  = fend_q[frp_q];

`ifndef SYNTH
  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_wr |-> (fcnt_q < FCW'(cnms_pkg::FifoDepth)) || m_beat)
    else $error("result written into a full output queue");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= w_p1)
    else $error("owed pixel count beyond one row plus one");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> ##4 fifo_wr)
    else $error("released pixel did not reach the output queue");

  a_credit_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q >= fcnt_q)
    else $error("credit count below queued results");
`endif

endmodule

`default_nettype wire

@@ rtl/cnms_center.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cnms_center #(
  parameter int  MAX_WIDTH = cnms_pkg::DefMaxWidth,
  parameter int  MAG_BITS  = cnms_pkg::DefMagBits,
  localparam int AW        = $clog2(2 * MAX_WIDTH + 8)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       wr_en_i,
  input  wire [AW-1:0]              wr_addr_i,
  input  wire [MAG_BITS-1:0]        wr_mag_i,
  input  cnms_pkg::cnms_sector_e    wr_sector_i,
  input  cnms_pkg::cnms_tok_t       tok_i,
  input  wire [AW-1:0]              addr_i,
  output cnms_pkg::cnms_tok_t       tok_o,
  output logic [AW-1:0]             addr_o,
  output logic [MAG_BITS-1:0]       cmag_o
);

  localparam int Depth = 2 ** AW;

  logic [MAG_BITS+1:0] mem [Depth];
  logic [MAG_BITS+1:0] rd_q;
  cnms_pkg::cnms_tok_t tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_sector_i, wr_mag_i};
    end
    rd_q   <= mem[addr_i];
    addr_o <= addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.sector = cnms_pkg::cnms_sector_e'(rd_q[MAG_BITS+1:MAG_BITS]);
    cmag_o       = rd_q[MAG_BITS-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/cnms_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cnms_cell #(
  parameter int  MAX_WIDTH  = cnms_pkg::DefMaxWidth,
  parameter int  MAG_BITS   = cnms_pkg::DefMagBits,
  parameter bit  LATER_SIDE = 1'b0,
  localparam int AW         = $clog2(2 * MAX_WIDTH + 8),
  localparam int W_BITS     = $clog2(MAX_WIDTH + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  wr_en_i,
  input  wire [AW-1:0]         wr_addr_i,
  input  wire [MAG_BITS-1:0]   wr_mag_i,
  input  wire [W_BITS-1:0]     width_i,
  input  cnms_pkg::cnms_tok_t  tok_i,
  input  wire [AW-1:0]         addr_i,
  input  wire [MAG_BITS-1:0]   cmag_i,
  output cnms_pkg::cnms_tok_t  tok_o,
  output logic [AW-1:0]        addr_o,
  output logic [MAG_BITS-1:0]  cmag_o
);

  localparam int Depth  = 2 ** AW;

  logic [MAG_BITS-1:0] mem [Depth];
  logic [MAG_BITS-1:0] nb_q;
  logic [AW-1:0]       w_a;
  logic [AW-1:0]       off;
  logic [AW-1:0]       nb_addr;
  logic                nb_ok;
  cnms_pkg::cnms_tok_t tok_q;

  assign w_a = AW'(width_i);

  always_comb begin
    unique case (tok_i.sector)
      cnms_pkg::SECT_VERT:    off = w_a;
      cnms_pkg::SECT_DIAG_DN: off = w_a + AW'(1);
      cnms_pkg::SECT_HORZ:    off = AW'(1);
      cnms_pkg::SECT_DIAG_UP: off = w_a - AW'(1);
      default:                off = w_a;
    endcase
    nb_addr = LATER_SIDE ? (addr_i + off) : (addr_i - off);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_mag_i;
    end
    nb_q   <= mem[nb_addr];
    addr_o <= addr_i;
    cmag_o <= cmag_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_comb begin
    nb_ok      = LATER_SIDE ? tok_q.ok_hi[tok_q.sector] : tok_q.ok_lo[tok_q.sector];
    tok_o      = tok_q;
    tok_o.supp = tok_q.supp | (nb_ok & (cmag_o < nb_q));
  end

endmodule

`default_nettype wire
